// File: design/pba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

  localparam int WORD_BITS  = 64;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = 12;
  // log2 of the bytes one bitmap word covers (4096 * 64)
  localparam int WORD_SHIFT = 18;

  localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ABOVE = 2'd1;
  localparam logic [1:0] ST_BELOW = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] CFG_REGION_START = 2'd0;
  localparam logic [1:0] CFG_REGION_END   = 2'd1;
  localparam logic [1:0] CFG_WORDS_IN_USE = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] page_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_used;
    logic [63:0] granted_addr;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/pba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/page_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                          Handshake
// -------   -----------------------------  --------------------------------------
// input     start, busy, in_item           item taken at edge with start & !busy
// result    out_valid, out_item            one-cycle strobe, receiver cannot stall
// config    cfg_we, cfg_index, cfg_wdata   write at edge with cfg_we high
//
// After reset a clearing pass zeroes the bitmap, one word a cycle, with busy held
// high. Query and free pass through the end check, start check, word range check
// and the registered bitmap read, each a step of the shared adder or the RAM, and
// may answer after any of them. Allocate streams one word a cycle: a hit goes on
// through the increment and grant steps, while a full map answers once every live
// word has been read. Busy drops as the result shows; the receiver cannot stall.
module page_bitmap_allocator_unit #(
  parameter int MAP_WORDS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire pba_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output pba_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata
);

  // word index width and word count width (count covers words_in_use too)
  localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW_M  = $clog2(MAP_WORDS + 1);
  localparam int CW    = (CW_M > 7) ? CW_M : 7;
  localparam logic [CW-1:0] MAP_CNT  = CW'(MAP_WORDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAP_WORDS - 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK1  = 4'd2;
  localparam logic [3:0] S_CHK2  = 4'd3;
  localparam logic [3:0] S_CHK3  = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_INC   = 4'd7;
  localparam logic [3:0] S_GRANT = 4'd8;

  // control state
  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [CW-1:0] issue_idx_r, issue_idx_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   region_start_r;
  logic [63:0]   region_end_r;
  logic [6:0]    words_in_use_r;

  // payload state
  logic [1:0]    op_r, op_nxt;
  logic [63:0]   addr_r, addr_nxt;
  logic [63:0]   off_r, off_nxt;
  logic [AW-1:0] widx_r, widx_nxt;
  logic [5:0]    bit_r, bit_nxt;
  logic [63:0]   word_r, word_nxt;
  pba_pkg::out_item_t out_r, out_nxt;

  // shared adder / subtractor
  logic [63:0] add_a, add_b;
  logic        add_sub;
  logic [64:0] add_sum;
  logic        add_carry;

  // bitmap port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  logic [CW-1:0] live_words;
  logic          in_range;
  logic [63:0]   first_zero;
  logic [5:0]    zero_pos;

  assign add_sum   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + 65'(add_sub);
  assign add_carry = add_sum[64];

  // clamp the word count to the bitmap depth
  assign live_words = (CW'(words_in_use_r) > MAP_CNT) ? MAP_CNT : CW'(words_in_use_r);

  assign in_range = (off_r[63:pba_pkg::WORD_SHIFT+CW] == '0) &&
                    (off_r[pba_pkg::WORD_SHIFT+CW-1:pba_pkg::WORD_SHIFT] < live_words);

  // in S_INC the adder holds word_r + 1: its lowest new bit is the first clear one
  assign first_zero = ~word_r & add_sum[63:0];

  always_comb begin
    zero_pos = '0;
    for (int i = 0; i < 64; i++) begin
      zero_pos = zero_pos | (first_zero[i] ? 6'(i) : 6'd0);
    end
  end

  pba_ram #(
    .WIDTH (pba_pkg::WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    issue_idx_nxt = issue_idx_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    off_nxt       = off_r;
    widx_nxt      = widx_r;
    bit_nxt       = bit_r;
    word_nxt      = word_r;
    out_nxt       = out_r;

    add_a     = region_end_r;
    add_b     = addr_r;
    add_sub   = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = widx_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = issue_idx_r[AW-1:0];

    case (state_r)
      S_CLR: begin
        // zero one bitmap word a cycle
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_nxt   = in_item.opcode;
          addr_nxt = in_item.page_addr;
          case (in_item.opcode)
            pba_pkg::OP_QUERY, pba_pkg::OP_FREE: begin
              state_nxt = S_CHK1;
            end
            pba_pkg::OP_ALLOC: begin
              issue_idx_nxt = '0;
              pend_nxt      = 1'b0;
              state_nxt     = S_SCAN;
            end
            default: begin
              // unused opcode: answer ok with nothing done
              out_valid_nxt        = 1'b1;
              out_nxt.status       = pba_pkg::ST_OK;
              out_nxt.is_used      = 1'b0;
              out_nxt.granted_addr = '0;
            end
          endcase
        end
      end

      S_CHK1: begin
        // region_end - addr: a borrow means the address lies above the end
        out_nxt.is_used      = 1'b0;
        out_nxt.granted_addr = '0;
        if (!add_carry) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = pba_pkg::ST_ABOVE;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_CHK2;
        end
      end

      S_CHK2: begin
        // addr - region_start: a borrow means below start, else the offset
        add_a = addr_r;
        add_b = region_start_r;
        if (!add_carry) begin
          out_valid_nxt   = 1'b1;
          out_nxt.status  = pba_pkg::ST_BELOW;
          out_nxt.is_used = (op_r == pba_pkg::OP_QUERY);
          state_nxt       = S_IDLE;
        end else begin
          off_nxt   = add_sum[63:0];
          state_nxt = S_CHK3;
        end
      end

      S_CHK3: begin
        if (in_range) begin
          ram_re    = 1'b1;
          ram_raddr = off_r[pba_pkg::WORD_SHIFT+AW-1:pba_pkg::WORD_SHIFT];
          widx_nxt  = off_r[pba_pkg::WORD_SHIFT+AW-1:pba_pkg::WORD_SHIFT];
          bit_nxt   = off_r[pba_pkg::WORD_SHIFT-1:pba_pkg::PAGE_SHIFT];
          state_nxt = S_RD;
        end else begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = pba_pkg::ST_ABOVE;
          state_nxt      = S_IDLE;
        end
      end

      S_RD: begin
        out_valid_nxt  = 1'b1;
        out_nxt.status = pba_pkg::ST_OK;
        state_nxt      = S_IDLE;
        if (op_r == pba_pkg::OP_QUERY) begin
          out_nxt.is_used = ram_rdata[bit_r];
        end else begin
          // drop the page's bit
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~(64'd1 << bit_r);
        end
      end

      S_SCAN: begin
        // check the word read last cycle while the next read is issued
        if (pend_r && (ram_rdata != pba_pkg::ALL_ONES)) begin
          word_nxt  = ram_rdata;
          state_nxt = S_INC;
        end else if (issue_idx_r < live_words) begin
          ram_re        = 1'b1;
          pend_nxt      = 1'b1;
          widx_nxt      = issue_idx_r[AW-1:0];
          issue_idx_nxt = issue_idx_r + CW'(1);
        end else begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = pba_pkg::ST_FULL;
          out_nxt.is_used      = 1'b0;
          out_nxt.granted_addr = '0;
          state_nxt            = S_IDLE;
        end
      end

      S_INC: begin
        // word + 1 locates the first clear bit; word | (word + 1) sets it
        add_a     = word_r;
        add_b     = 64'd1;
        add_sub   = 1'b0;
        word_nxt  = word_r | add_sum[63:0];
        bit_nxt   = zero_pos;
        state_nxt = S_GRANT;
      end

      S_GRANT: begin
        ram_we    = 1'b1;
        ram_wdata = word_r;
        add_a     = region_start_r;
        add_b     = (64'(widx_r) << pba_pkg::WORD_SHIFT) |
                    (64'(bit_r) << pba_pkg::PAGE_SHIFT);
        add_sub   = 1'b0;
        out_valid_nxt        = 1'b1;
        out_nxt.status       = pba_pkg::ST_OK;
        out_nxt.is_used      = 1'b0;
        out_nxt.granted_addr = add_sum[63:0];
        state_nxt            = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLR;
      clr_idx_r      <= '0;
      issue_idx_r    <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      region_start_r <= '0;
      region_end_r   <= '0;
      words_in_use_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      issue_idx_r <= issue_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pba_pkg::CFG_REGION_START: region_start_r <= cfg_wdata;
          pba_pkg::CFG_REGION_END:   region_end_r   <= cfg_wdata;
          pba_pkg::CFG_WORDS_IN_USE: words_in_use_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    addr_r <= addr_nxt;
    off_r  <= off_nxt;
    widx_r <= widx_nxt;
    bit_r  <= bit_nxt;
    word_r <= word_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire
